>>> src/ps2sc_pkg.sv
// Shared types, scancode constants and US layout tables for the scancode decoder.
package ps2sc_pkg;

    localparam logic [7:0] SC_EXT_PREFIX  = 8'hE0;
    localparam logic [7:0] SC_LSHIFT_MAKE = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BRK  = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BRK  = 8'hB6;
    localparam logic [7:0] SC_CAPS_MAKE   = 8'h3A;
    localparam logic [7:0] SC_UP          = 8'h48;
    localparam logic [7:0] SC_DOWN        = 8'h50;
    localparam logic [7:0] SC_LEFT        = 8'h4B;
    localparam logic [7:0] SC_RIGHT       = 8'h4D;
    localparam logic [7:0] SC_DELETE      = 8'h53;

    localparam logic [2:0] SPK_NONE   = 3'd0;
    localparam logic [2:0] SPK_UP     = 3'd1;
    localparam logic [2:0] SPK_DOWN   = 3'd2;
    localparam logic [2:0] SPK_LEFT   = 3'd3;
    localparam logic [2:0] SPK_RIGHT  = 3'd4;
    localparam logic [2:0] SPK_DELETE = 3'd5;

    localparam logic [6:0] CHAR_LOWER_A = 7'h61;
    localparam logic [6:0] CHAR_LOWER_Z = 7'h7A;

    localparam int FLAGS_W = 3;
    localparam int TAB_LEN = 64;

    typedef struct packed {
        logic ext;
        logic shift;
        logic caps;
    } flags_t;

    typedef struct packed {
        logic       valid;
        logic [6:0] char_code;
        logic [2:0] special_key;
    } result_t;

    localparam logic [6:0] PLAIN_TAB [TAB_LEN] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
        7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68,
        7'h6A, 7'h6B, 7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    localparam logic [6:0] UPPER_TAB [TAB_LEN] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
        7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48,
        7'h4A, 7'h4B, 7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

endpackage

>>> src/ps2_scancode_to_ascii.sv
// Top level: PS/2 set-1 scancode to ASCII decoder, US layout.
// A request is registered into s1 and decoded; the result goes to output registers.
// Throughput: one request per cycle unless the output stalls. The flag word is in a
// one-entry registered-read RAM; a write-back bypass covers back-to-back requests.
// Reset: asynchronous, clears the pipeline valids and the flag-word valid bit,
// so the flags read as zero until first written.
module ps2_scancode_to_ascii (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] scan_code,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] char_code,
    output logic [2:0] special_key
);

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [7:0]          s1_code_reg;
    logic                hit_reg;
    logic                hit_next;
    ps2sc_pkg::flags_t   fwd_reg;
    logic                mem_valid_reg;
    logic                mem_valid_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [6:0]          char_reg;
    logic [2:0]          key_reg;

    logic                in_fire;
    logic                s1_fire;
    logic                out_free;
    logic [ps2sc_pkg::FLAGS_W-1:0] ram_rdata;
    ps2sc_pkg::flags_t   flags_cur;
    ps2sc_pkg::flags_t   flags_new;
    ps2sc_pkg::result_t  result;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && (!result.valid || out_free);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_fire  = in_valid && !in_stall;

    ps2sc_ram #(
        .WIDTH (ps2sc_pkg::FLAGS_W),
        .DEPTH (1)
    ) u_flag_ram (
        .clk   (clk),
        .re    (in_fire),
        .we    (s1_fire),
        .addr  (1'b0),
        .wdata (flags_new),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (hit_reg)
        begin
            flags_cur = fwd_reg;
        end
        else if (mem_valid_reg)
        begin
            flags_cur = ram_rdata;
        end
        else
        begin
            flags_cur = '0;
        end
    end

    ps2sc_decode u_decode (
        .scan_code (s1_code_reg),
        .flags_cur (flags_cur),
        .flags_new (flags_new),
        .result    (result)
    );

    always_comb
    begin
        s1_valid_next  = in_fire || (s1_valid_reg && !s1_fire);
        hit_next       = in_fire ? s1_fire : hit_reg;
        mem_valid_next = mem_valid_reg || s1_fire;
        out_valid_next = out_valid_reg && out_stall;
        if (s1_fire && result.valid)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            mem_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            hit_reg       <= hit_next;
            mem_valid_reg <= mem_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_code_reg <= scan_code;
        end
        if (s1_fire)
        begin
            fwd_reg <= flags_new;
        end
        if (s1_fire && result.valid)
        begin
            char_reg <= result.char_code;
            key_reg  <= result.special_key;
        end
    end

    assign out_valid   = out_valid_reg;
    assign char_code   = char_reg;
    assign special_key = key_reg;

endmodule

>>> src/ps2sc_ram.sv
// Generic single-port RAM with registered read.
module ps2sc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             re,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/ps2sc_decode.sv
// Flag update and character lookup for one scancode.
module ps2sc_decode (
    input  logic                    [7:0] scan_code,
    input  ps2sc_pkg::flags_t             flags_cur,
    output ps2sc_pkg::flags_t             flags_new,
    output ps2sc_pkg::result_t            result
);

    logic [5:0] idx;
    logic [6:0] base;
    logic [6:0] ch;
    logic       is_letter;

    assign idx       = scan_code[5:0];
    assign base      = ps2sc_pkg::PLAIN_TAB[idx];
    assign is_letter = (base >= ps2sc_pkg::CHAR_LOWER_A) && (base <= ps2sc_pkg::CHAR_LOWER_Z);

    always_comb
    begin
        if (is_letter)
        begin
            ch = (flags_cur.shift ^ flags_cur.caps) ? {base[6], 1'b0, base[4:0]} : base;
        end
        else
        begin
            ch = flags_cur.shift ? ps2sc_pkg::UPPER_TAB[idx] : base;
        end
    end

    always_comb
    begin
        flags_new          = flags_cur;
        result.valid       = 1'b0;
        result.char_code   = 7'd0;
        result.special_key = ps2sc_pkg::SPK_NONE;
        if (scan_code == ps2sc_pkg::SC_EXT_PREFIX)
        begin
            flags_new.ext = 1'b1;
        end
        else if (scan_code == ps2sc_pkg::SC_LSHIFT_MAKE || scan_code == ps2sc_pkg::SC_RSHIFT_MAKE)
        begin
            flags_new.shift = 1'b1;
        end
        else if (scan_code == ps2sc_pkg::SC_LSHIFT_BRK || scan_code == ps2sc_pkg::SC_RSHIFT_BRK)
        begin
            flags_new.shift = 1'b0;
        end
        else if (scan_code == ps2sc_pkg::SC_CAPS_MAKE)
        begin
            flags_new.caps = ~flags_cur.caps;
        end
        else if (flags_cur.ext)
        begin
            flags_new.ext = 1'b0;
            case (scan_code)
                ps2sc_pkg::SC_UP:
                begin
                    result.valid       = 1'b1;
                    result.special_key = ps2sc_pkg::SPK_UP;
                end
                ps2sc_pkg::SC_DOWN:
                begin
                    result.valid       = 1'b1;
                    result.special_key = ps2sc_pkg::SPK_DOWN;
                end
                ps2sc_pkg::SC_LEFT:
                begin
                    result.valid       = 1'b1;
                    result.special_key = ps2sc_pkg::SPK_LEFT;
                end
                ps2sc_pkg::SC_RIGHT:
                begin
                    result.valid       = 1'b1;
                    result.special_key = ps2sc_pkg::SPK_RIGHT;
                end
                ps2sc_pkg::SC_DELETE:
                begin
                    result.valid       = 1'b1;
                    result.special_key = ps2sc_pkg::SPK_DELETE;
                end
                default:
                begin
                    result.valid = 1'b0;
                end
            endcase
        end
        else if (scan_code[7:6] == 2'b00 && ch != 7'd0)
        begin
            result.valid     = 1'b1;
            result.char_code = ch;
        end
    end

endmodule

>>> src/ps2sc_checker.sv
// Port-level assertions for the scancode decoder, bound to the top level.
module ps2sc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] scan_code,
    input logic       out_valid,
    input logic       out_stall,
    input logic [6:0] char_code,
    input logic [2:0] special_key
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(scan_code))
        else $error("request dropped or changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(char_code) && $stable(special_key))
        else $error("result changed while stalled");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((char_code == 7'd0) != (special_key == ps2sc_pkg::SPK_NONE)))
        else $error("result must carry exactly one of character or special key");

    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> special_key <= ps2sc_pkg::SPK_DELETE)
        else $error("special key code out of range");

endmodule

bind ps2_scancode_to_ascii ps2sc_checker u_ps2sc_checker (.*);

>>> dv/ps2_scancode_to_ascii_test.sv
// Self-checking testbench for the PS/2 set-1 scancode to ASCII decoder.
`timescale 1ns / 100ps

module ps2_scancode_to_ascii_test;

    localparam int LAYOUT_LEN  = 59;
    localparam int REQ_TARGET  = 550;
    localparam int QUIET_TAIL  = 60;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [7:0] code;
        bit         drain_first;
    } scan_req_t;

    typedef struct {
        logic [6:0] ch;
        logic [2:0] key;
    } key_event_t;

    localparam logic [7:0] US_PLAIN [LAYOUT_LEN] = '{
        8'd0, 8'd27, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0",
        "-", "=", 8'd8, 8'd9, "q", "w", "e", "r", "t", "y", "u", "i",
        "o", "p", "[", "]", 8'd10, 8'd0, "a", "s", "d", "f", "g", "h",
        "j", "k", "l", ";", "'", 8'h60, 8'd0, 8'h5C, "z", "x", "c", "v",
        "b", "n", "m", ",", ".", "/", 8'd0, "*", 8'd0, " ", 8'd0
    };

    localparam logic [7:0] US_SHIFTED [LAYOUT_LEN] = '{
        8'd0, 8'd27, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")",
        "_", "+", 8'd8, 8'd9, "Q", "W", "E", "R", "T", "Y", "U", "I",
        "O", "P", "{", "}", 8'd10, 8'd0, "A", "S", "D", "F", "G", "H",
        "J", "K", "L", ":", 8'h22, "~", 8'd0, "|", "Z", "X", "C", "V",
        "B", "N", "M", "<", ">", "?", 8'd0, "*", 8'd0, " ", 8'd0
    };

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic [7:0] scan_code   = 8'h00;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic [6:0] char_code;
    logic [2:0] special_key;

    scan_req_t  pending_reqs [$];
    key_event_t expected_keys [$];

    bit ext_seen;
    bit shift_down;
    bit caps_on;

    int total_reqs;
    int sent_total      = 0;
    int predicted_total = 0;
    int checked_total   = 0;
    int cycle_count     = 0;
    int errors          = 0;
    int gap_left        = 0;
    int stall_left      = 0;

    ps2_scancode_to_ascii dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .scan_code   (scan_code),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .char_code   (char_code),
        .special_key (special_key)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit decode_scancode(input logic [7:0] sc);
        logic [7:0] base;
        logic [7:0] ch;
        key_event_t ev;
        ev.ch  = 7'd0;
        ev.key = ps2sc_pkg::SPK_NONE;
        if (sc == ps2sc_pkg::SC_EXT_PREFIX)
        begin
            ext_seen = 1'b1;
            return 1'b0;
        end
        if (sc == ps2sc_pkg::SC_LSHIFT_MAKE || sc == ps2sc_pkg::SC_RSHIFT_MAKE)
        begin
            shift_down = 1'b1;
            return 1'b0;
        end
        if (sc == ps2sc_pkg::SC_LSHIFT_BRK || sc == ps2sc_pkg::SC_RSHIFT_BRK)
        begin
            shift_down = 1'b0;
            return 1'b0;
        end
        if (sc == ps2sc_pkg::SC_CAPS_MAKE)
        begin
            caps_on = !caps_on;
            return 1'b0;
        end
        if (ext_seen)
        begin
            ext_seen = 1'b0;
            if (sc[7])
                return 1'b0;
            case (sc)
                ps2sc_pkg::SC_UP:     ev.key = ps2sc_pkg::SPK_UP;
                ps2sc_pkg::SC_DOWN:   ev.key = ps2sc_pkg::SPK_DOWN;
                ps2sc_pkg::SC_LEFT:   ev.key = ps2sc_pkg::SPK_LEFT;
                ps2sc_pkg::SC_RIGHT:  ev.key = ps2sc_pkg::SPK_RIGHT;
                ps2sc_pkg::SC_DELETE: ev.key = ps2sc_pkg::SPK_DELETE;
                default:              return 1'b0;
            endcase
            expected_keys.push_back(ev);
            return 1'b1;
        end
        if (sc[7] || sc >= LAYOUT_LEN)
            return 1'b0;
        base = US_PLAIN[sc];
        if (base == 8'd0)
            return 1'b0;
        if (base >= "a" && base <= "z")
            ch = (shift_down != caps_on) ? base - 8'd32 : base;
        else
            ch = shift_down ? US_SHIFTED[sc] : base;
        if (ch == 8'd0)
            return 1'b0;
        ev.ch = ch[6:0];
        expected_keys.push_back(ev);
        return 1'b1;
    endfunction

    task automatic queue_scan(input logic [7:0] code, input bit drain_first = 1'b0);
        scan_req_t req;
        req.code        = code;
        req.drain_first = drain_first;
        pending_reqs.push_back(req);
    endtask

    // request driver
    always @(posedge clk)
    begin
        scan_req_t  req;
        logic       nxt_valid;
        logic [7:0] nxt_code;
        bit         took;
        bit         produced;
        bit         idle_on;
        took     = 1'b0;
        produced = 1'b0;
        if (rst_n)
        begin
            nxt_valid = in_valid;
            nxt_code  = scan_code;
            idle_on   = ((total_reqs - pending_reqs.size()) / 80) % 3 != 0;
            if (in_valid && !in_stall)
            begin
                took      = 1'b1;
                produced  = decode_scancode(scan_code);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_reqs.size() > 0)
                begin
                    if (pending_reqs[0].drain_first &&
                        predicted_total + produced != checked_total)
                        ;
                    else if (idle_on && pending_reqs.size() > QUIET_TAIL &&
                             $urandom_range(0, 5) == 0)
                        gap_left = $urandom_range(0, 8);
                    else
                    begin
                        req       = pending_reqs.pop_front();
                        nxt_valid = 1'b1;
                        nxt_code  = req.code;
                    end
                end
            end
            in_valid        <= nxt_valid;
            scan_code       <= nxt_code;
            sent_total      <= sent_total + took;
            predicted_total <= predicted_total + produced;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        key_event_t want;
        logic       nxt_stall;
        bit         took;
        took = 1'b0;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                took = 1'b1;
                if (expected_keys.size() == 0)
                begin
                    $display("%0t: unexpected result: char_code %h special_key %0d",
                             $time, char_code, special_key);
                    errors++;
                end
                else
                begin
                    want = expected_keys.pop_front();
                    if (char_code !== want.ch)
                    begin
                        $display("%0t: char_code expected %h, actual %h",
                                 $time, want.ch, char_code);
                        errors++;
                    end
                    if (special_key !== want.key)
                    begin
                        $display("%0t: special_key expected %0d, actual %0d",
                                 $time, want.key, special_key);
                        errors++;
                    end
                end
            end
            nxt_stall = 1'b0;
            if (stall_left > 0)
            begin
                stall_left--;
                nxt_stall = 1'b1;
            end
            else if (sent_total < total_reqs - QUIET_TAIL && (checked_total / 40) % 3 != 1 &&
                     $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 8);
                nxt_stall  = 1'b1;
            end
            out_stall     <= nxt_stall;
            checked_total <= checked_total + took;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int         pick;
        int         n;
        logic [7:0] code;
        logic [7:0] nav [5];
        nav = '{ps2sc_pkg::SC_UP, ps2sc_pkg::SC_DOWN, ps2sc_pkg::SC_LEFT,
                ps2sc_pkg::SC_RIGHT, ps2sc_pkg::SC_DELETE};

        queue_scan(8'h00);
        queue_scan(8'h01);
        queue_scan(8'h1E);
        queue_scan(ps2sc_pkg::SC_LSHIFT_MAKE);
        queue_scan(8'h02);
        queue_scan(8'h1E);
        queue_scan(ps2sc_pkg::SC_EXT_PREFIX);
        queue_scan(ps2sc_pkg::SC_LSHIFT_BRK);
        queue_scan(ps2sc_pkg::SC_UP);
        queue_scan(ps2sc_pkg::SC_CAPS_MAKE);
        queue_scan(8'h10);
        queue_scan(ps2sc_pkg::SC_RSHIFT_MAKE);
        queue_scan(8'h10);
        queue_scan(8'h29);
        queue_scan(ps2sc_pkg::SC_RSHIFT_BRK);
        queue_scan(ps2sc_pkg::SC_EXT_PREFIX);
        queue_scan(ps2sc_pkg::SC_DOWN);
        queue_scan(ps2sc_pkg::SC_EXT_PREFIX);
        queue_scan(ps2sc_pkg::SC_LEFT);
        queue_scan(ps2sc_pkg::SC_EXT_PREFIX);
        queue_scan(ps2sc_pkg::SC_RIGHT);
        queue_scan(ps2sc_pkg::SC_EXT_PREFIX);
        queue_scan(ps2sc_pkg::SC_DELETE);
        queue_scan(ps2sc_pkg::SC_EXT_PREFIX);
        queue_scan(8'h39);
        queue_scan(8'hFF, 1'b1);

        while (pending_reqs.size() < REQ_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                code = 8'($urandom_range(1, 8'h58));
                queue_scan(code, pending_reqs.size() == 300);
                if ($urandom_range(0, 3) != 0)
                    queue_scan(code | 8'h80);
            end
            else if (pick < 57)
            begin
                queue_scan($urandom_range(0, 1) ? ps2sc_pkg::SC_LSHIFT_MAKE
                                                : ps2sc_pkg::SC_RSHIFT_MAKE);
                n = $urandom_range(1, 5);
                repeat (n)
                    queue_scan(8'($urandom_range(1, 8'h39)));
                queue_scan($urandom_range(0, 1) ? ps2sc_pkg::SC_LSHIFT_BRK
                                                : ps2sc_pkg::SC_RSHIFT_BRK);
            end
            else if (pick < 63)
            begin
                queue_scan(ps2sc_pkg::SC_CAPS_MAKE);
                queue_scan(ps2sc_pkg::SC_CAPS_MAKE | 8'h80);
            end
            else if (pick < 80)
            begin
                code = $urandom_range(0, 3) != 0 ? nav[$urandom_range(0, 4)]
                                                 : 8'($urandom_range(0, 127));
                queue_scan(ps2sc_pkg::SC_EXT_PREFIX);
                queue_scan(code);
                if ($urandom_range(0, 1))
                begin
                    queue_scan(ps2sc_pkg::SC_EXT_PREFIX);
                    queue_scan(code | 8'h80);
                end
            end
            else
                queue_scan(8'($urandom_range(0, 255)));
        end
        total_reqs = pending_reqs.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        while (sent_total != total_reqs || checked_total != predicted_total)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
        if (errors == 0 && expected_keys.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
src/ps2sc_pkg.sv
src/ps2sc_ram.sv
src/ps2sc_decode.sv
src/ps2_scancode_to_ascii.sv
src/ps2sc_checker.sv
dv/ps2_scancode_to_ascii_test.sv
